// ----- rtl/core/rmq_pkg.sv -----
package rmq_pkg;

    // pipeline shape
    localparam int unsigned SQ_STAGES  = 4;   // square root stages
    localparam int unsigned SQ_PER     = 4;   // root bits resolved per stage
    localparam int unsigned DV_STAGES  = 8;   // divider stages
    localparam int unsigned DV_PER     = 4;   // quotient bits resolved per stage
    localparam int unsigned DV_LANES   = 3;   // parts taken from the divider
    localparam int unsigned NUM_STAGES = 1 + SQ_STAGES + 1 + DV_STAGES;

    localparam logic signed [18:0] ONE_Q14     = 19'sd16384;
    localparam logic signed [18:0] DEGEN_LIMIT = 19'sd16;

    typedef enum logic [1:0] {
        PART_W = 2'd0,
        PART_X = 2'd1,
        PART_Y = 2'd2,
        PART_Z = 2'd3
    } t_part;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic [1:0]         largest_part;
        logic               degenerate;
    } t_out_word;

    // everything one item carries down the pipeline
    typedef struct packed {
        t_part                              idx;
        logic                               degen;
        logic [31:0]                        sq_v;
        logic [15:0]                        sq_root;
        logic [19:0]                        sq_rem;
        logic [15:0]                        b;
        logic [DV_LANES-1:0]                neg;
        logic [DV_LANES-1:0][31:0]          num;
        logic [DV_LANES-1:0][31:0]          quo;
        logic [DV_LANES-1:0][15:0]          drem;
    } t_stg;

endpackage

// ----- rtl/core/rotation_matrix_to_quaternion.sv -----
// rotation matrix to unit quaternion, all values signed q1.14. each word in
// gives one word out. the block is a 15-stage pipeline: one stage forms the
// four diagonal sums and picks the largest (ties go to w, then x, y, z), four
// stages run a digit-by-digit square root at four root bits per stage, one
// stage halves and rounds the root and builds the dividends, and eight stages
// run three restoring dividers in parallel at four quotient bits per stage;
// the last stage is the output register. a new word is taken every cycle
// while o_stall is low. o_stall is high only while a finished word sits
// in the output register and i_stall holds it; the whole pipeline then holds.
// when the square root argument is 16 raw or less (never for a real rotation)
// all parts and largest_part read zero and degenerate is set.
module rotation_matrix_to_quaternion (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  rmq_pkg::t_in_word    i_word,
    output logic                 o_valid,
    input  logic                 i_stall,
    output rmq_pkg::t_out_word   o_word
);
    import rmq_pkg::*;

    localparam int unsigned SQ_FIRST = 1;
    localparam int unsigned B_STAGE  = 1 + SQ_STAGES;
    localparam int unsigned DV_FIRST = B_STAGE + 1;

    t_stg      r_stg [NUM_STAGES];
    t_stg      n_stg [NUM_STAGES];
    logic      r_vld [NUM_STAGES];
    t_out_word r_out;
    t_out_word n_out;
    logic      r_out_vld;
    logic      adv;

    // one square root digit: bring down two radicand bits, try root*4+1
    function automatic t_stg sq_step(input t_stg s);
        t_stg        o;
        logic [19:0] r;
        logic [19:0] tr;
        o  = s;
        r  = {s.sq_rem[17:0], s.sq_v[31:30]};
        tr = {2'b00, s.sq_root, 2'b01};
        if (r >= tr) begin
            o.sq_rem  = r - tr;
            o.sq_root = {s.sq_root[14:0], 1'b1};
        end else begin
            o.sq_rem  = r;
            o.sq_root = {s.sq_root[14:0], 1'b0};
        end
        o.sq_v = {s.sq_v[29:0], 2'b00};
        return o;
    endfunction

    // one restoring division step in every lane
    function automatic t_stg dv_step(input t_stg s);
        t_stg        o;
        logic [16:0] r;
        o = s;
        for (int j = 0; j < DV_LANES; j++) begin
            r = {s.drem[j], s.num[j][31]};
            if (r >= {1'b0, s.b}) begin
                o.drem[j] = 16'(r - {1'b0, s.b});
                o.quo[j]  = {s.quo[j][30:0], 1'b1};
            end else begin
                o.drem[j] = r[15:0];
                o.quo[j]  = {s.quo[j][30:0], 1'b0};
            end
            o.num[j] = {s.num[j][30:0], 1'b0};
        end
        return o;
    endfunction

    // whole pipeline moves unless the output word is held
    assign adv     = !r_out_vld || !i_stall;
    assign o_stall = !adv;
    assign o_valid = r_out_vld;
    assign o_word  = r_out;

    // front stage: diagonal sums, largest pick, off-diagonal pairs
    always_comb begin
        logic signed [17:0] tw, tx, ty, tz, best;
        logic signed [18:0] arg;
        logic signed [16:0] da, db, dc, dx, dy, dz;
        logic signed [16:0] d [DV_LANES];
        logic signed [16:0] mg;
        n_stg[0] = '0;
        tw = 18'(i_word.m00) + 18'(i_word.m11) + 18'(i_word.m22);
        tx = 18'(i_word.m00) - 18'(i_word.m11) - 18'(i_word.m22);
        ty = 18'(i_word.m11) - 18'(i_word.m00) - 18'(i_word.m22);
        tz = 18'(i_word.m22) - 18'(i_word.m00) - 18'(i_word.m11);
        best         = tw;
        n_stg[0].idx = PART_W;
        if (tx > best) begin
            best         = tx;
            n_stg[0].idx = PART_X;
        end
        if (ty > best) begin
            best         = ty;
            n_stg[0].idx = PART_Y;
        end
        if (tz > best) begin
            best         = tz;
            n_stg[0].idx = PART_Z;
        end
        arg            = 19'(best) + ONE_Q14;
        n_stg[0].degen = (arg <= DEGEN_LIMIT);
        // radicand is arg * 2^14
        n_stg[0].sq_v  = {1'b0, arg[16:0], 14'b0};

        da = 17'(i_word.m12) - 17'(i_word.m21);
        db = 17'(i_word.m20) - 17'(i_word.m02);
        dc = 17'(i_word.m01) - 17'(i_word.m10);
        dx = 17'(i_word.m01) + 17'(i_word.m10);
        dy = 17'(i_word.m20) + 17'(i_word.m02);
        dz = 17'(i_word.m12) + 17'(i_word.m21);
        // lanes hold the non-root parts in w, x, y, z order
        unique case (n_stg[0].idx)
            PART_W: begin
                d[0] = da; d[1] = db; d[2] = dc;
            end
            PART_X: begin
                d[0] = da; d[1] = dx; d[2] = dy;
            end
            PART_Y: begin
                d[0] = db; d[1] = dx; d[2] = dz;
            end
            PART_Z: begin
                d[0] = dc; d[1] = dy; d[2] = dz;
            end
            default: begin
                d[0] = da; d[1] = db; d[2] = dc;
            end
        endcase
        for (int j = 0; j < DV_LANES; j++) begin
            n_stg[0].neg[j] = d[j][16];
            mg              = d[j][16] ? -d[j] : d[j];
            // magnitude parked in the dividend field until the root is known
            n_stg[0].num[j] = {15'b0, mg};
        end
    end

    // square root stages
    for (genvar s = SQ_FIRST; s < B_STAGE; s++) begin : g_sq
        always_comb begin
            n_stg[s] = r_stg[s-1];
            for (int k = 0; k < SQ_PER; k++) begin
                n_stg[s] = sq_step(n_stg[s]);
            end
        end
    end

    // halve the root with rounding, build rounded dividends
    always_comb begin
        logic [16:0] rp1;
        n_stg[B_STAGE]   = r_stg[B_STAGE-1];
        rp1              = {1'b0, r_stg[B_STAGE-1].sq_root} + 17'd1;
        n_stg[B_STAGE].b = rp1[16:1];
        for (int j = 0; j < DV_LANES; j++) begin
            n_stg[B_STAGE].num[j]  = {3'b0, r_stg[B_STAGE-1].num[j][16:0], 12'b0}
                                   + {17'b0, rp1[16:2]};
            n_stg[B_STAGE].quo[j]  = '0;
            n_stg[B_STAGE].drem[j] = '0;
        end
    end

    // divider stages
    for (genvar s = DV_FIRST; s < NUM_STAGES; s++) begin : g_dv
        always_comb begin
            n_stg[s] = r_stg[s-1];
            for (int k = 0; k < DV_PER; k++) begin
                n_stg[s] = dv_step(n_stg[s]);
            end
        end
    end

    // saturate, sign and place the parts
    always_comb begin
        t_stg               f;
        logic signed [15:0] q [DV_LANES];
        logic signed [15:0] p [4];
        f = r_stg[NUM_STAGES-1];
        for (int j = 0; j < DV_LANES; j++) begin
            if (f.neg[j]) begin
                q[j] = (f.quo[j] > 32'd32768) ? 16'sh8000 : -$signed(f.quo[j][15:0]);
            end else begin
                q[j] = (f.quo[j] > 32'd32767) ? 16'sh7fff : $signed(f.quo[j][15:0]);
            end
        end
        for (int k = 0; k < 4; k++) begin
            if (2'(k) == f.idx) begin
                p[k] = $signed(f.b);
            end else if (2'(k) < f.idx) begin
                p[k] = q[k];
            end else begin
                p[k] = q[(k > 0) ? k - 1 : 0];
            end
        end
        if (f.degen) begin
            n_out = '0;
            n_out.degenerate = 1'b1;
        end else begin
            n_out.quat_w       = p[0];
            n_out.quat_x       = p[1];
            n_out.quat_y       = p[2];
            n_out.quat_z       = p[3];
            n_out.largest_part = f.idx;
            n_out.degenerate   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_STAGES; s++) begin
                r_vld[s] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < NUM_STAGES; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
            r_out_vld <= r_vld[NUM_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int s = 0; s < NUM_STAGES; s++) begin
                r_stg[s] <= n_stg[s];
            end
            r_out <= n_out;
        end
    end

endmodule

// ----- tb/rotation_matrix_to_quaternion_tb.sv -----
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_tb;
    import rmq_pkg::*;

    localparam int N_RANDOM   = 600;
    localparam int PAUSE_AT   = 320;   // sender waits here until all quaternions are back
    localparam int HOLD_AT    = 150;   // receiver holds off after this many words out
    localparam int HOLD_LEN   = 300;
    localparam int DRAIN_WAIT = 40;    // a bit more than the pipeline latency
    localparam int IDLE_LIMIT = 3000;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       i_stall = 1'b0;
    t_in_word   i_word  = '0;
    logic       o_stall;
    logic       o_valid;
    t_out_word  o_word;

    rotation_matrix_to_quaternion dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word)
    );

    always #2 i_clk = ~i_clk;

    t_in_word  matrix_q[$];      // matrices waiting to be sent
    t_out_word quat_q[$];        // quaternions expected, oldest first
    bit        rst_done   = 1'b0;
    bit        in_took    = 1'b0; // input word accepted at the last rising edge
    int        words_sent = 0;
    int        words_got  = 0;
    int        errors     = 0;
    int        idle_count = 0;

    // round(d*4096/b), halves away from zero, saturated to 16 bits
    function automatic logic signed [15:0] scaled_part(int d, int b);
        longint mag;
        longint q;
        mag = (d < 0) ? -longint'(d) : longint'(d);
        mag = mag << 12;
        q = (mag + (b >> 1)) / b;
        if (d < 0)
            return (q > 32768) ? -16'sd32768 : 16'(-q);
        return (q > 32767) ? 16'sd32767 : 16'(q);
    endfunction

    // quaternion expected for one matrix
    function automatic t_out_word convert_matrix(t_in_word m);
        int        t[4];
        int        best;
        int        b;
        longint    arg;
        longint    v;
        longint    res;
        longint    bitv;
        t_part     idx;
        t_out_word r;
        t[0] = int'(m.m00) + int'(m.m11) + int'(m.m22);
        t[1] = int'(m.m00) - int'(m.m11) - int'(m.m22);
        t[2] = int'(m.m11) - int'(m.m00) - int'(m.m22);
        t[3] = int'(m.m22) - int'(m.m00) - int'(m.m11);
        best = t[0];
        idx  = PART_W;
        // strict compare, so earlier parts win ties
        for (int k = 1; k < 4; k++) begin
            if (t[k] > best) begin
                best = t[k];
                idx  = t_part'(k);
            end
        end
        r = '0;
        arg = longint'(best) + 16384;
        if (arg <= 16) begin
            r.degenerate = 1'b1;
            return r;
        end
        // integer square root of arg * 2^14, then halve with rounding
        v    = arg << 14;
        res  = 0;
        bitv = 64'sd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        b = int'((res + 1) >> 1);
        case (idx)
            PART_W: begin
                r.quat_w = 16'(b);
                r.quat_x = scaled_part(int'(m.m12) - int'(m.m21), b);
                r.quat_y = scaled_part(int'(m.m20) - int'(m.m02), b);
                r.quat_z = scaled_part(int'(m.m01) - int'(m.m10), b);
            end
            PART_X: begin
                r.quat_w = scaled_part(int'(m.m12) - int'(m.m21), b);
                r.quat_x = 16'(b);
                r.quat_y = scaled_part(int'(m.m01) + int'(m.m10), b);
                r.quat_z = scaled_part(int'(m.m20) + int'(m.m02), b);
            end
            PART_Y: begin
                r.quat_w = scaled_part(int'(m.m20) - int'(m.m02), b);
                r.quat_x = scaled_part(int'(m.m01) + int'(m.m10), b);
                r.quat_y = 16'(b);
                r.quat_z = scaled_part(int'(m.m12) + int'(m.m21), b);
            end
            default: begin
                r.quat_w = scaled_part(int'(m.m01) - int'(m.m10), b);
                r.quat_x = scaled_part(int'(m.m20) + int'(m.m02), b);
                r.quat_y = scaled_part(int'(m.m12) + int'(m.m21), b);
                r.quat_z = 16'(b);
            end
        endcase
        r.largest_part = idx;
        return r;
    endfunction

    function automatic t_in_word diag_matrix(int d0, int d1, int d2);
        t_in_word m;
        m = '0;
        m.m00 = 16'(d0);
        m.m11 = 16'(d1);
        m.m22 = 16'(d2);
        return m;
    endfunction

    // signed permutation of the identity with a little noise on every element
    function automatic t_in_word near_rotation();
        logic signed [15:0] e[9];
        int                 perm[3];
        int                 j;
        int                 tmp;
        int                 noise;
        perm = '{0, 1, 2};
        for (int i = 2; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
        end
        noise = ($urandom_range(0, 3) == 0) ? 3000 : 150;
        for (int i = 0; i < 9; i++)
            e[i] = 16'($urandom_range(0, 2 * noise) - noise);
        for (int i = 0; i < 3; i++)
            e[3 * i + perm[i]] = 16'(($urandom_range(0, 1) ? 16384 : -16384)
                                     + int'(e[3 * i + perm[i]]));
        return {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    endfunction

    function automatic t_in_word random_matrix();
        t_in_word m;
        case ($urandom_range(0, 3))
            0: begin
                // full-range noise, reaches every bit and the saturation
                for (int i = 0; i < 9; i++) m[16 * i +: 16] = 16'($urandom);
            end
            1: begin
                // small elements, lots of near-ties on the diagonal
                for (int i = 0; i < 9; i++)
                    m[16 * i +: 16] = 16'($urandom_range(0, 64) - 32);
            end
            default: m = near_rotation();
        endcase
        return m;
    endfunction

    // rising edge: note input acceptance and check output words
    always @(posedge i_clk) begin
        t_out_word want;
        in_took <= i_valid && !o_stall && i_rst_n;
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_count <= 0;
            end else begin
                idle_count <= idle_count + 1;
            end
            if (i_valid && !o_stall) begin
                quat_q.push_back(convert_matrix(i_word));
            end
            if (o_valid && !i_stall) begin
                words_got  <= words_got + 1;
                if (quat_q.size() == 0) begin
                    $error("quaternion word with nothing expected: %h", o_word);
                    errors++;
                end else begin
                    want = quat_q.pop_front();
                    if (o_word.quat_w !== want.quat_w) begin
                        $error("quat_w expected %0d got %0d", want.quat_w, o_word.quat_w);
                        errors++;
                    end
                    if (o_word.quat_x !== want.quat_x) begin
                        $error("quat_x expected %0d got %0d", want.quat_x, o_word.quat_x);
                        errors++;
                    end
                    if (o_word.quat_y !== want.quat_y) begin
                        $error("quat_y expected %0d got %0d", want.quat_y, o_word.quat_y);
                        errors++;
                    end
                    if (o_word.quat_z !== want.quat_z) begin
                        $error("quat_z expected %0d got %0d", want.quat_z, o_word.quat_z);
                        errors++;
                    end
                    if (o_word.largest_part !== want.largest_part) begin
                        $error("largest_part expected %0d got %0d",
                               want.largest_part, o_word.largest_part);
                        errors++;
                    end
                    if (o_word.degenerate !== want.degenerate) begin
                        $error("degenerate expected %0d got %0d",
                               want.degenerate, o_word.degenerate);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if (idle_count >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // sender: bursts of random length, random gaps, one pause until drained
    int burst_left = 0;
    int gap_left   = 0;
    always @(negedge i_clk) begin : driver
        bit next_valid;
        if (rst_done && !(i_valid && !in_took)) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (matrix_q.size() != 0 &&
                         !(words_sent == PAUSE_AT && quat_q.size() != 0)) begin
                i_word <= matrix_q.pop_front();
                words_sent++;
                next_valid = 1'b1;
                if (burst_left == 0) burst_left = $urandom_range(1, 40);
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
            i_valid <= next_valid;
        end
    end

    // receiver: stall pattern that steps through four modes in turn, one long hold
    int  rx_cycle  = 0;
    int  hold_left = 0;
    bit  held_once = 1'b0;
    always @(negedge i_clk) begin : receiver
        int mode;
        if (rst_done) begin
            rx_cycle++;
            mode = (rx_cycle / 64) % 4;
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!held_once && words_got >= HOLD_AT) begin
                held_once = 1'b1;
                hold_left = HOLD_LEN - 1;
                i_stall <= 1'b1;
            end else begin
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    2: i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= (rx_cycle % 5 == 0);
                endcase
            end
        end
    end

    initial begin
        // directed: identity, each largest part, ties, extremes of the elements
        matrix_q.push_back(diag_matrix(16384, 16384, 16384));
        matrix_q.push_back(diag_matrix(16384, -16384, -16384));
        matrix_q.push_back(diag_matrix(-16384, 16384, -16384));
        matrix_q.push_back(diag_matrix(-16384, -16384, 16384));
        matrix_q.push_back(diag_matrix(0, 0, 0));            // four-way tie, w wins
        matrix_q.push_back(diag_matrix(0, 0, -16384));       // x and y tie
        matrix_q.push_back(diag_matrix(0, -16384, 0));       // x and z tie
        matrix_q.push_back(diag_matrix(-16384, 0, 0));       // y and z tie
        matrix_q.push_back('0);
        matrix_q.push_back({9{16'sh7fff}});
        matrix_q.push_back({9{16'sh8000}});
        matrix_q.push_back({9{16'shffff}});
        matrix_q.push_back({16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                            16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});
        matrix_q.push_back({16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                            16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff});
        matrix_q.push_back({16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000,
                            16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000});
        // 90 degrees about z, and a half turn about x
        matrix_q.push_back({16'sd0, -16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'sd0,
                            16'sd0, 16'sd0, 16'sd16384});
        matrix_q.push_back({16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0,
                            16'sd0, 16'sd0, -16'sd16384});
        for (int i = 0; i < 4; i++) matrix_q.push_back(near_rotation());
        for (int i = 0; i < N_RANDOM; i++) matrix_q.push_back(random_matrix());

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done <= 1'b1;

        wait (matrix_q.size() == 0 && !i_valid);
        wait (quat_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0 && quat_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/rmq_pkg.sv
rtl/core/rotation_matrix_to_quaternion.sv
tb/rotation_matrix_to_quaternion_tb.sv
